FILE: hw/rtl/wbpm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wildcard bit pattern match count: shared package
// Types, register indexes, fixed widths and limits used by the top, front and back.
// ----------------------------------------------------------------------------
package wbpm_pkg;

	// Fixed limits of the text stream and the pattern.
	localparam int MAX_PATTERN_BITS = 64;
	localparam int MAX_TEXT_BITS    = 1048576;
	localparam int WINDOW_STRIDE    = 8;
	localparam int STRIDE_SHIFT     = $clog2(WINDOW_STRIDE);

	// Field widths.
	localparam int NIBBLE_W  = 4;
	localparam int LEN_W     = 7;
	localparam int INDEX_W   = 17;
	localparam int COUNT_W   = 7;
	localparam int BITCNT_W  = 21;
	localparam int REG_IDX_W = 2;
	localparam int DATA_W    = 64;

	// Configuration register indexes.
	localparam logic [REG_IDX_W-1:0] REG_PATTERN_VALUE  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_PATTERN_CARE   = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd2;

	// One completed window, handed from the front to the back.
	typedef struct packed {
		logic [INDEX_W-1:0]          index;
		logic [MAX_PATTERN_BITS-1:0] bits;
	} window_item_t;

	// One finished result.
	typedef struct packed {
		logic [INDEX_W-1:0] index;
		logic [COUNT_W-1:0] count;
	} result_t;

	// Clamp the programmed length into the supported range.
	function automatic logic [LEN_W-1:0] eff_length(input logic [LEN_W-1:0] len);
		logic [LEN_W-1:0] m;
		m = len;
		if (m == '0) begin
			m = LEN_W'(1);
		end else if (m > LEN_W'(MAX_PATTERN_BITS)) begin
			m = LEN_W'(MAX_PATTERN_BITS);
		end
		return m;
	endfunction

endpackage

FILE: hw/rtl/wildcard_bit_pattern_match_count_top.sv
`timescale 1ns / 1ps
// Throughput: one nibble per cycle while full is low; the front shifts all four
// bits of a nibble combinationally. A completed window goes through the window
// queue, then the three count stages and the result queue, to the result ports.
// The count pipeline is credit-gated by the result queue and never stalls.
// Reset clears the bit history, bit count, queues and registers (length 1).
// ----------------------------------------------------------------------------
// Wildcard bit pattern match count: top level
// Counts wildcard-or-equal pattern positions for every byte-aligned window of
// a nibble text stream, with queue-style handshakes on both sides.
// ----------------------------------------------------------------------------
module wildcard_bit_pattern_match_count_top #(
	parameter int MID_DEPTH = 4,
	parameter int OUT_DEPTH = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic [wbpm_pkg::NIBBLE_W-1:0]     text_nibble,
	input  logic                              text_last,
	output logic                              empty,
	input  logic                              pop,
	output logic [wbpm_pkg::INDEX_W-1:0]      window_index,
	output logic [wbpm_pkg::COUNT_W-1:0]      match_count,
	input  logic                              wr_en,
	input  logic [wbpm_pkg::REG_IDX_W-1:0]    wr_index,
	input  logic [wbpm_pkg::DATA_W-1:0]       wr_data
);

	localparam int PB = wbpm_pkg::MAX_PATTERN_BITS;
	localparam int LW = wbpm_pkg::LEN_W;

	logic [PB-1:0]          pattern_value_q;
	logic [PB-1:0]          pattern_care_q;
	logic [LW-1:0]          pattern_length_q;
	logic [LW-1:0]          eff_len;
	logic                   in_accept;
	logic                   mid_push;
	wbpm_pkg::window_item_t mid_wr_item;
	wbpm_pkg::window_item_t mid_rd_item;
	logic                   mid_empty;
	logic                   mid_full;
	logic                   mid_pop;
	logic                   out_push;
	wbpm_pkg::result_t      out_wr_res;
	wbpm_pkg::result_t      out_rd_res;
	logic                   out_full;
	logic                   out_pop;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_value_q  <= '0;
			pattern_care_q   <= '0;
			pattern_length_q <= LW'(1);
		end else if (wr_en) begin
			case (wr_index)
				wbpm_pkg::REG_PATTERN_VALUE: begin
					pattern_value_q <= wr_data;
				end
				wbpm_pkg::REG_PATTERN_CARE: begin
					pattern_care_q <= wr_data;
				end
				wbpm_pkg::REG_PATTERN_LENGTH: begin
					pattern_length_q <= wr_data[LW-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign eff_len   = wbpm_pkg::eff_length(pattern_length_q);
	assign full      = mid_full;
	assign in_accept = push && !mid_full;
	assign out_pop   = pop && !empty;

	// Front end: history, bit count and window detection.
	wbpm_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (in_accept),
		.text_nibble (text_nibble),
		.text_last   (text_last),
		.pattern_len (eff_len),
		.emit        (mid_push),
		.emit_item   (mid_wr_item)
	);

	// Queue of completed windows between front and back.
	wbpm_fifo #(
		.WIDTH ($bits(wbpm_pkg::window_item_t)),
		.DEPTH (MID_DEPTH)
	) u_mid_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (mid_push),
		.wr_data (mid_wr_item),
		.rd_en   (mid_pop),
		.rd_data (mid_rd_item),
		.empty   (mid_empty),
		.full    (mid_full)
	);

	// Back end: masked match count pipeline.
	wbpm_back #(
		.OUT_DEPTH (OUT_DEPTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (!mid_empty),
		.item          (mid_rd_item),
		.pattern_value (pattern_value_q),
		.pattern_care  (pattern_care_q),
		.pattern_len   (eff_len),
		.item_take     (mid_pop),
		.res_valid     (out_push),
		.res           (out_wr_res),
		.res_pop       (out_pop)
	);

	// Result queue facing the consumer.
	wbpm_fifo #(
		.WIDTH ($bits(wbpm_pkg::result_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (out_push),
		.wr_data (out_wr_res),
		.rd_en   (out_pop),
		.rd_data (out_rd_res),
		.empty   (empty),
		.full    (out_full)
	);

	assign window_index = out_rd_res.index;
	assign match_count  = out_rd_res.count;

	// The credit scheme must keep the result queue from overflowing.
	a_out_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |-> !out_full)
		else $error("result queue written while full");

	// A result leaves the count pipeline only for a window taken into stage 1.
	a_pipe_latency: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |-> $past(mid_pop, 3))
		else $error("result without a matching window transaction");

	// The back end only takes a window that is waiting.
	a_take_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		mid_pop |-> !mid_empty)
		else $error("window queue read while empty");

endmodule

FILE: hw/rtl/wbpm_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wildcard bit pattern match count: small queue
// Register-based first-in first-out queue with empty and full flags.
// ----------------------------------------------------------------------------
module wbpm_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty,
	output logic             full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign empty   = (count_q == '0);
	assign full    = (count_q == CNT_W'(DEPTH));
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// Storage is written without reset; the count guards every read.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

FILE: hw/rtl/wbpm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wildcard bit pattern match count: front end
// Shifts each accepted nibble into the bit history, tracks the bit count and
// picks out the first byte-aligned window that completes within the nibble.
// ----------------------------------------------------------------------------
module wbpm_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               accept,
	input  logic [wbpm_pkg::NIBBLE_W-1:0]      text_nibble,
	input  logic                               text_last,
	input  logic [wbpm_pkg::LEN_W-1:0]         pattern_len,
	output logic                               emit,
	output wbpm_pkg::window_item_t             emit_item
);

	localparam int NW = wbpm_pkg::NIBBLE_W;
	localparam int PB = wbpm_pkg::MAX_PATTERN_BITS;
	localparam int BW = wbpm_pkg::BITCNT_W;
	localparam int SS = wbpm_pkg::STRIDE_SHIFT;
	localparam int IW = wbpm_pkg::INDEX_W;

	logic [PB-1:0] hist_q;
	logic [BW-1:0] bits_q;
	logic [PB-1:0] hist_n;
	logic [BW-1:0] bits_n;
	logic [BW-1:0] start;
	logic          found;

	// Walk the four bits of the nibble, most significant first.
	always_comb begin
		hist_n    = hist_q;
		bits_n    = bits_q;
		start     = '0;
		found     = 1'b0;
		emit_item = '0;
		for (int i = 0; i < NW; i++) begin
			if (bits_n < BW'(wbpm_pkg::MAX_TEXT_BITS)) begin
				hist_n = {hist_n[PB-2:0], text_nibble[NW-1-i]};
				bits_n = bits_n + BW'(1);
				start  = bits_n - BW'(pattern_len);
				if (!found && (bits_n >= BW'(pattern_len)) && (start[SS-1:0] == '0)) begin
					found           = 1'b1;
					emit_item.index = start[IW+SS-1:SS];
					emit_item.bits  = hist_n;
				end
			end
		end
		emit = accept && found;
	end

	// History and bit count; the end of a text clears both.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '0;
			bits_q <= '0;
		end else if (accept) begin
			if (text_last) begin
				hist_q <= '0;
				bits_q <= '0;
			end else begin
				hist_q <= hist_n;
				bits_q <= bits_n;
			end
		end
	end

endmodule

FILE: hw/rtl/wbpm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wildcard bit pattern match count: back end
// Three-stage pipeline that aligns a window to the pattern, marks matching or
// wildcard positions and counts them. Credits keep the result queue from
// overflowing, so the pipeline never stalls.
// ----------------------------------------------------------------------------
module wbpm_back #(
	parameter int OUT_DEPTH = 8
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  item_valid,
	input  wbpm_pkg::window_item_t                item,
	input  logic [wbpm_pkg::MAX_PATTERN_BITS-1:0] pattern_value,
	input  logic [wbpm_pkg::MAX_PATTERN_BITS-1:0] pattern_care,
	input  logic [wbpm_pkg::LEN_W-1:0]            pattern_len,
	output logic                                  item_take,
	output logic                                  res_valid,
	output wbpm_pkg::result_t                     res,
	input  logic                                  res_pop
);

	localparam int PB     = wbpm_pkg::MAX_PATTERN_BITS;
	localparam int LW     = wbpm_pkg::LEN_W;
	localparam int IW     = wbpm_pkg::INDEX_W;
	localparam int CW     = wbpm_pkg::COUNT_W;
	localparam int GROUPS = PB / 8;
	localparam int CRED_W = $clog2(OUT_DEPTH + 1);

	logic [CRED_W-1:0]  credit_q;
	logic [PB-1:0]      rev;
	logic [LW-1:0]      shamt;
	logic [PB-1:0]      aligned;
	logic [PB-1:0]      len_mask;
	logic               valid_s1;
	logic [IW-1:0]      index_s1;
	logic [PB-1:0]      match_s1;
	logic               valid_s2;
	logic [IW-1:0]      index_s2;
	logic [3:0]         part_s2 [GROUPS];
	logic [3:0]         part_n  [GROUPS];
	logic               valid_s3;
	logic [IW-1:0]      index_s3;
	logic [CW-1:0]      count_s3;
	logic [CW-1:0]      sum_n;

	// Take an item only when the result queue has room reserved for it.
	assign item_take = item_valid && (credit_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= CRED_W'(OUT_DEPTH);
		end else if (item_take && !res_pop) begin
			credit_q <= credit_q - CRED_W'(1);
		end else if (res_pop && !item_take) begin
			credit_q <= credit_q + CRED_W'(1);
		end
	end

	// Stage 1: pattern symbol j faces history bit (length - 1 - j).
	always_comb begin
		for (int j = 0; j < PB; j++) begin
			rev[j] = item.bits[PB-1-j];
		end
		shamt    = LW'(PB) - pattern_len;
		aligned  = rev >> shamt;
		len_mask = {PB{1'b1}} >> shamt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= item_take;
		end
	end

	always_ff @(posedge clk) begin
		index_s1 <= item.index;
		match_s1 <= len_mask & (~pattern_care | ~(aligned ^ pattern_value));
	end

	// Stage 2: a population count over each group of eight positions.
	always_comb begin
		for (int g = 0; g < GROUPS; g++) begin
			part_n[g] = '0;
			for (int b = 0; b < 8; b++) begin
				part_n[g] = part_n[g] + 4'(match_s1[g*8+b]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		index_s2 <= index_s1;
		part_s2  <= part_n;
	end

	// Stage 3: add the group counts.
	always_comb begin
		sum_n = '0;
		for (int g = 0; g < GROUPS; g++) begin
			sum_n = sum_n + CW'(part_s2[g]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		index_s3 <= index_s2;
		count_s3 <= sum_n;
	end

	assign res_valid = valid_s3;
	assign res.index = index_s3;
	assign res.count = count_s3;

endmodule
